// ===== rtl/ttb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants for the triangle tangent/bitangent block.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int TEX_FRAC_BITS = 16;
    localparam int POS_W  = 32;
    localparam int TEX_W  = 24;
    localparam int EDGE_W = POS_W + 1;
    localparam int UV_W   = TEX_W + 1;
    localparam int PROD_W = EDGE_W + UV_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int DET_W  = 2 * UV_W + 1;
    localparam int QUO_W  = 32 + TEX_FRAC_BITS;
    localparam int NUM_ACC = 7;
    localparam int NUM_RES = 6;
    localparam logic [3:0] MUL_LAST = 4'd14;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [TEX_W-1:0] tex_u;
        logic signed [TEX_W-1:0] tex_v;
    } t_vertex;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
        logic               last_of_triangle;
    } t_result;

    typedef struct packed {
        logic signed [EDGE_W-1:0] e1_x;
        logic signed [EDGE_W-1:0] e1_y;
        logic signed [EDGE_W-1:0] e1_z;
        logic signed [EDGE_W-1:0] e2_x;
        logic signed [EDGE_W-1:0] e2_y;
        logic signed [EDGE_W-1:0] e2_z;
        logic signed [UV_W-1:0]   u1;
        logic signed [UV_W-1:0]   v1;
        logic signed [UV_W-1:0]   u2;
        logic signed [UV_W-1:0]   v2;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_RUN,
        DV_FINISH
    } t_div_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/ttb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_front
// Holds the first two vertices of a triangle and pushes edge/UV-delta jobs.
// ----------------------------------------------------------------------------
module ttb_front import ttb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_vertex i_data,
    output logic         o_stall,
    input  wire logic    i_full,
    output logic         o_push,
    output t_job         o_job
);

    logic [1:0] r_phase;
    t_vertex    r_held [2];
    logic       accept;

    assign o_stall = r_phase[1] & i_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = accept & r_phase[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (accept) begin
            r_phase <= r_phase[1] ? 2'd0 : r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_phase[1]) begin
            r_held[r_phase[0]] <= i_data;
        end
    end

    always_comb begin
        o_job.e1_x = {r_held[1].pos_x[POS_W-1], r_held[1].pos_x}
                   - {r_held[0].pos_x[POS_W-1], r_held[0].pos_x};
        o_job.e1_y = {r_held[1].pos_y[POS_W-1], r_held[1].pos_y}
                   - {r_held[0].pos_y[POS_W-1], r_held[0].pos_y};
        o_job.e1_z = {r_held[1].pos_z[POS_W-1], r_held[1].pos_z}
                   - {r_held[0].pos_z[POS_W-1], r_held[0].pos_z};
        o_job.e2_x = {i_data.pos_x[POS_W-1], i_data.pos_x}
                   - {r_held[0].pos_x[POS_W-1], r_held[0].pos_x};
        o_job.e2_y = {i_data.pos_y[POS_W-1], i_data.pos_y}
                   - {r_held[0].pos_y[POS_W-1], r_held[0].pos_y};
        o_job.e2_z = {i_data.pos_z[POS_W-1], i_data.pos_z}
                   - {r_held[0].pos_z[POS_W-1], r_held[0].pos_z};
        o_job.u1   = {r_held[1].tex_u[TEX_W-1], r_held[1].tex_u}
                   - {r_held[0].tex_u[TEX_W-1], r_held[0].tex_u};
        o_job.v1   = {r_held[1].tex_v[TEX_W-1], r_held[1].tex_v}
                   - {r_held[0].tex_v[TEX_W-1], r_held[0].tex_v};
        o_job.u2   = {i_data.tex_u[TEX_W-1], i_data.tex_u}
                   - {r_held[0].tex_u[TEX_W-1], r_held[0].tex_u};
        o_job.v2   = {i_data.tex_v[TEX_W-1], i_data.tex_v}
                   - {r_held[0].tex_v[TEX_W-1], r_held[0].tex_v};
    end

endmodule
`default_nettype wire

// ===== rtl/ttb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module ttb_queue import ttb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_job    i_job,
    input  wire logic    i_pop,
    output t_job         o_job,
    output t_queue_status o_status
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = r_count[1];
    assign do_push = i_push & ~o_status.full;
    assign do_pop  = i_pop & ~o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ttb_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_divider
// Bit-serial signed divide: round(num * 2^16 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module ttb_divider import ttb_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_num,
    input  wire logic signed [DET_W-1:0] i_den,
    output logic                         o_done,
    output logic [31:0]                  o_quo
);

    t_div_state         r_state;
    t_div_state         n_state;
    logic [ACC_W-1:0]   r_n;
    logic [DET_W-1:0]   r_d;
    logic [DET_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_q;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic               r_sat;

    logic               sat;
    logic               in_bit;
    logic [4:0]         bit_idx;
    logic [DET_W:0]     shifted;
    logic               ge;
    logic [DET_W:0]     trial;
    logic               rnd;
    logic [QUO_W:0]     sum;
    logic [QUO_W:0]     lim;
    logic [QUO_W:0]     mag;

    assign sat     = {{(DET_W + 32 - ACC_W){1'b0}}, r_n} >= {r_d, 32'd0};
    assign bit_idx = 5'(r_cnt - 6'd16);
    assign in_bit  = (r_cnt >= 6'd16) ? r_n[bit_idx] : 1'b0;
    assign shifted = {r_rem, in_bit};
    assign ge      = shifted >= {1'b0, r_d};
    assign trial   = shifted - {1'b0, r_d};
    assign rnd     = {r_rem, 1'b0} >= {1'b0, r_d};
    assign sum     = {1'b0, r_q} + {{QUO_W{1'b0}}, rnd};
    assign lim     = r_neg ? (QUO_W+1)'(33'h080000000) : (QUO_W+1)'(33'h07FFFFFFF);
    assign mag     = (r_sat || sum > lim) ? lim : sum;

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:   if (i_start) n_state = DV_CHECK;
            DV_CHECK:  n_state = sat ? DV_FINISH : DV_RUN;
            DV_RUN:    if (r_cnt == 6'd0) n_state = DV_FINISH;
            DV_FINISH: n_state = DV_IDLE;
            default:   n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_FINISH);
        o_quo  = r_neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                r_neg <= i_num[ACC_W-1] ^ i_den[DET_W-1];
                r_n   <= i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
                r_d   <= i_den[DET_W-1] ? DET_W'(-i_den) : DET_W'(i_den);
            end
            DV_CHECK: begin
                r_sat <= sat;
                r_rem <= DET_W'(r_n[ACC_W-1:32]);
                r_q   <= '0;
                r_cnt <= 6'(QUO_W - 1);
            end
            DV_RUN: begin
                r_rem <= ge ? trial[DET_W-1:0] : shifted[DET_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], ge};
                r_cnt <= r_cnt - 6'd1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ttb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ttb_back
// Pops jobs, forms determinant and numerators on one shared multiplier,
// divides on the serial divider and emits three results per triangle.
// ----------------------------------------------------------------------------
module ttb_back import ttb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_job    i_job,
    input  wire logic    i_empty,
    output logic         o_pop,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    t_back_state               r_state;
    t_back_state               n_state;
    t_job                      r_job;
    logic [3:0]                r_step;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc [NUM_ACC];
    logic [31:0]               r_res [NUM_RES];
    logic [2:0]                r_idx;
    logic [1:0]                r_emit;

    logic signed [EDGE_W-1:0]  op_a;
    logic signed [UV_W-1:0]    op_b;
    logic [3:0]                prev;
    logic [2:0]                acc_idx;
    logic                      det_zero;
    logic signed [DET_W-1:0]   det;
    logic signed [ACC_W-1:0]   num;
    logic                      div_start;
    logic                      div_done;
    logic [31:0]               div_quo;
    logic                      out_take;

    assign prev     = r_step - 4'd1;
    assign acc_idx  = prev[3:1];
    assign det_zero = (r_acc[0] == '0);
    assign det      = r_acc[0][DET_W-1:0];
    assign num      = r_acc[3'(r_idx + 3'd1)];
    assign out_take = (r_state == BK_OUT) && !i_stall;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_step[3:1])
            3'd0: begin
                op_a = r_step[0] ? EDGE_W'(r_job.v1) : EDGE_W'(r_job.u1);
                op_b = r_step[0] ? r_job.u2 : r_job.v2;
            end
            3'd1: begin
                op_a = r_step[0] ? r_job.e2_x : r_job.e1_x;
                op_b = r_step[0] ? r_job.v1 : r_job.v2;
            end
            3'd2: begin
                op_a = r_step[0] ? r_job.e2_y : r_job.e1_y;
                op_b = r_step[0] ? r_job.v1 : r_job.v2;
            end
            3'd3: begin
                op_a = r_step[0] ? r_job.e2_z : r_job.e1_z;
                op_b = r_step[0] ? r_job.v1 : r_job.v2;
            end
            3'd4: begin
                op_a = r_step[0] ? r_job.e1_x : r_job.e2_x;
                op_b = r_step[0] ? r_job.u2 : r_job.u1;
            end
            3'd5: begin
                op_a = r_step[0] ? r_job.e1_y : r_job.e2_y;
                op_b = r_step[0] ? r_job.u2 : r_job.u1;
            end
            3'd6: begin
                op_a = r_step[0] ? r_job.e1_z : r_job.e2_z;
                op_b = r_step[0] ? r_job.u2 : r_job.u1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:      if (!i_empty) n_state = BK_MUL;
            BK_MUL:       if (r_step == MUL_LAST) n_state = BK_DIV_START;
            BK_DIV_START: n_state = det_zero ? BK_OUT : BK_DIV_WAIT;
            BK_DIV_WAIT: begin
                if (div_done) n_state = (r_idx == 3'(NUM_RES - 1)) ? BK_OUT : BK_DIV_START;
            end
            BK_OUT:       if (out_take && r_emit == 2'd2) n_state = BK_IDLE;
            default:      n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == BK_IDLE) && !i_empty;
        div_start = (r_state == BK_DIV_START) && !det_zero;
        o_valid   = (r_state == BK_OUT);
        o_data.tangent_x        = det_zero ? '0 : r_res[0];
        o_data.tangent_y        = det_zero ? '0 : r_res[1];
        o_data.tangent_z        = det_zero ? '0 : r_res[2];
        o_data.bitangent_x      = det_zero ? '0 : r_res[3];
        o_data.bitangent_y      = det_zero ? '0 : r_res[4];
        o_data.bitangent_z      = det_zero ? '0 : r_res[5];
        o_data.degenerate       = det_zero;
        o_data.last_of_triangle = (r_emit == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_emit  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (out_take) r_emit <= (r_emit == 2'd2) ? 2'd0 : r_emit + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        case (r_state)
            BK_IDLE: begin
                r_job  <= i_job;
                r_step <= 4'd0;
                r_idx  <= 3'd0;
            end
            BK_MUL: begin
                r_step <= r_step + 4'd1;
                if (r_step != 4'd0) begin
                    if (prev[0]) r_acc[acc_idx] <= r_acc[acc_idx] - ACC_W'(r_prod);
                    else         r_acc[acc_idx] <= ACC_W'(r_prod);
                end
            end
            BK_DIV_WAIT: begin
                if (div_done) begin
                    r_res[r_idx] <= div_quo;
                    r_idx        <= r_idx + 3'd1;
                end
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    ttb_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (det),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

endmodule
`default_nettype wire

// ===== rtl/triangle_tangent_bitangent.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent
// Per-triangle tangent and bitangent from a vertex stream.
//
// Input channel: one vertex per transaction (i_in_valid / o_in_stall), every
// three vertices form a triangle. Output channel: three result transactions
// per triangle (o_out_valid / i_out_stall), last_of_triangle set on the third.
// The first two vertices of a triangle are held in the front; the third turns
// into a job in a two-entry queue, so vertices keep flowing while the back
// works on an earlier triangle.
// The back first forms its products on the shared multiplier, then runs 6
// divisions on the bit-serial divider (48 quotient bits), then emits 3
// results. A zero determinant skips the divider.
// Reset clears the vertex phase, the queue and both state machines.
// An output stall holds the current result and, once the queue fills, stalls
// the third vertex of the next triangle.
// ----------------------------------------------------------------------------
module triangle_tangent_bitangent import ttb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_vertex i_in_data,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_out_data
);

    t_queue_status q_status;
    t_job          push_job;
    t_job          head_job;
    logic          push;
    logic          pop;

    ttb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_job   (push_job)
    );

    ttb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    ttb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (q_status.empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule
`default_nettype wire
